@@ hw/rtl/remote_engine_start_sequencer_top_macros.svh @@
// Assertion macros for the remote engine start sequencer checker.
// Pulled in by the checker file; needs nothing else.
`ifndef REMOTE_ENGINE_START_SEQUENCER_TOP_MACROS_SVH
`define REMOTE_ENGINE_START_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define RESS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ress assertion failed");

// next-cycle implication
`define RESS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ress assertion failed");

`endif

@@ hw/rtl/ress_pkg.sv @@
// Shared types, codes and helpers for the remote engine start sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ress_pkg;

   localparam int unsigned TICKS_PER_SECOND   = 1000;
   localparam int unsigned SECONDS_PER_MINUTE = 60;

   localparam int unsigned MV_W     = 16;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned MILLIS_W = 10;
   localparam int unsigned SECS_W   = 6;
   localparam int unsigned CSR_IDX_W = 3;

   // engine phase codes
   localparam logic [1:0] PH_STOPPED  = 2'd0;
   localparam logic [1:0] PH_IGN_WAIT = 2'd1;
   localparam logic [1:0] PH_CRANK    = 2'd2;
   localparam logic [1:0] PH_RUN      = 2'd3;

   // input modes
   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_COMMAND = 1'b1;

   // link command codes
   localparam logic [7:0] CMD_BATTERY  = 8'd4;
   localparam logic [7:0] CMD_STOP     = 8'd5;
   localparam logic [7:0] CMD_IND_A    = 8'd8;
   localparam logic [7:0] CMD_IND_B    = 8'd9;
   localparam logic [7:0] CMD_START_10 = 8'd10;
   localparam logic [7:0] CMD_START_15 = 8'd15;
   localparam logic [7:0] CMD_START_20 = 8'd20;
   localparam logic [7:0] CMD_START_25 = 8'd25;
   localparam logic [7:0] CMD_START_30 = 8'd30;

   localparam logic [7:0] ARG_UNCHANGED = 8'd255;
   localparam logic [7:0] REPLY_BASE    = 8'd128;

   // reply data codes
   localparam logic [7:0] RD_OK       = 8'd1;
   localparam logic [7:0] RD_STARTING = 8'd4;
   localparam logic [7:0] RD_RUNNING  = 8'd7;

   // notice codes
   localparam logic [1:0] NT_STARTED = 2'd0;
   localparam logic [1:0] NT_FAILED  = 2'd1;
   localparam logic [1:0] NT_STOPPED = 2'd2;
   localparam logic [1:0] NT_RUNNING = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STARTER_STOP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENGINE_RUNNING = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_PRESENT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IGN_DELAY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CRANK_TIMEOUT  = 3'd4;

   localparam logic [MV_W-1:0] RST_STARTER_STOP   = 16'd12500;
   localparam logic [MV_W-1:0] RST_ENGINE_RUNNING = 16'd13000;
   localparam logic [MV_W-1:0] RST_KEY_PRESENT    = 16'd9000;
   localparam logic [MV_W-1:0] RST_IGN_DELAY      = 16'd3000;
   localparam logic [MV_W-1:0] RST_CRANK_TIMEOUT  = 16'd2000;

   localparam logic [BYTE_W-1:0] RST_INDICATOR = 8'd1;

   // mV / 100: saturates at 25600 and up, below that a reciprocal multiply
   localparam logic [MV_W-1:0] SAT_MV      = 16'd25600;
   localparam logic [12:0]     DIV100_RECIP = 13'd5243;   // ceil(2^19 / 100)
   localparam int unsigned     DIV100_SHIFT = 19;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] command_code;
      logic [BYTE_W-1:0] command_arg;
      logic [MV_W-1:0]   battery_mv;
      logic [MV_W-1:0]   accessory_mv;
   } req_type;

   typedef struct packed {
      logic              ignition_relay;
      logic              starter_relay;
      logic [BYTE_W-1:0] indicator_level;
      logic [1:0]        engine_phase;
      logic              reply_valid;
      logic [BYTE_W-1:0] reply_result;
      logic [BYTE_W-1:0] reply_data;
      logic              notice_valid;
      logic [1:0]        notice_code;
   } rsp_type;

   typedef struct packed {
      logic [MV_W-1:0] starter_stop_mv;
      logic [MV_W-1:0] engine_running_mv;
      logic [MV_W-1:0] key_present_mv;
      logic [MV_W-1:0] ignition_delay_ms;
      logic [MV_W-1:0] crank_timeout_ms;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] battery_div100(input logic [MV_W-1:0] mv);
      logic [27:0] prod;
      prod = 28'(mv[14:0]) * 28'(DIV100_RECIP);
      if (mv >= SAT_MV) begin
         return 8'd255;
      end
      return prod[DIV100_SHIFT +: BYTE_W];
   endfunction

endpackage

@@ hw/rtl/remote_engine_start_sequencer_top.sv @@
// Remote engine start sequencer: CSR bank, result register and handshake.
// Depends on ress_pkg and ress_step.
//
//   channel  ports                          direction  content
//   req      req_valid/req_stall/req_data   in         tick or link command + voltages
//   rsp      rsp_valid/rsp_stall/rsp_data   out        relays, phase, reply, notice
//   csr      csr_write_en/csr_index/csr_wdata in       threshold and timing registers
//
// One transaction per cycle while req_stall is low; each result is registered and appears in the
// cycle after acceptance. The throughput is set by the single result register, which is refilled in
// the same cycle it is drained. req_stall is high only while a result waits
// under rsp_stall. Synchronous reset clears sequencer state and loads the
// register defaults; no clearing sweep follows.
`timescale 1ns / 1ps

module remote_engine_start_sequencer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ress_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ress_pkg::rsp_type                  rsp_data,
   input  logic                               csr_write_en,
   input  logic [ress_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ress_pkg::MV_W-1:0]          csr_wdata
);

   ress_pkg::cfg_type cfg_ff;
   ress_pkg::rsp_type rsp_in;
   ress_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.starter_stop_mv   <= ress_pkg::RST_STARTER_STOP;
         cfg_ff.engine_running_mv <= ress_pkg::RST_ENGINE_RUNNING;
         cfg_ff.key_present_mv    <= ress_pkg::RST_KEY_PRESENT;
         cfg_ff.ignition_delay_ms <= ress_pkg::RST_IGN_DELAY;
         cfg_ff.crank_timeout_ms  <= ress_pkg::RST_CRANK_TIMEOUT;
      end else if (csr_write_en) begin
         case (csr_index)
            ress_pkg::REG_STARTER_STOP:   cfg_ff.starter_stop_mv   <= csr_wdata;
            ress_pkg::REG_ENGINE_RUNNING: cfg_ff.engine_running_mv <= csr_wdata;
            ress_pkg::REG_KEY_PRESENT:    cfg_ff.key_present_mv    <= csr_wdata;
            ress_pkg::REG_IGN_DELAY:      cfg_ff.ignition_delay_ms <= csr_wdata;
            ress_pkg::REG_CRANK_TIMEOUT:  cfg_ff.crank_timeout_ms  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ress_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .rsp    (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

@@ hw/rtl/ress_step.sv @@
// Sequencer state and per-transaction next-state logic.
// Depends on ress_pkg; instantiated by remote_engine_start_sequencer_top.
`timescale 1ns / 1ps

module ress_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  ress_pkg::req_type req,
   input  ress_pkg::cfg_type cfg,
   output ress_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      ST_STOPPED  = ress_pkg::PH_STOPPED,
      ST_IGN_WAIT = ress_pkg::PH_IGN_WAIT,
      ST_CRANK    = ress_pkg::PH_CRANK,
      ST_RUN      = ress_pkg::PH_RUN
   } phase_state_type;

   phase_state_type                     phase_ff, phase_in;
   logic [ress_pkg::MV_W-1:0]           timer_ff, timer_in;
   logic [ress_pkg::BYTE_W-1:0]         minutes_ff, minutes_in;
   logic [ress_pkg::MILLIS_W-1:0]       millis_ff, millis_in;
   logic [ress_pkg::SECS_W-1:0]         seconds_ff, seconds_in;
   logic                                remote_ff, remote_in;
   logic                                ign_ff, ign_in;
   logic [ress_pkg::BYTE_W-1:0]         indicator_ff, indicator_in;

   logic [ress_pkg::MV_W-1:0] timer_inc;

   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      minutes_in   = minutes_ff;
      millis_in    = millis_ff;
      seconds_in   = seconds_ff;
      remote_in    = remote_ff;
      ign_in       = ign_ff;
      indicator_in = indicator_ff;
      timer_inc    = timer_ff + 16'd1;

      rsp.reply_valid  = 1'b0;
      rsp.reply_result = '0;
      rsp.reply_data   = '0;
      rsp.notice_valid = 1'b0;
      rsp.notice_code  = ress_pkg::NT_STARTED;

      if (req.mode == ress_pkg::MODE_TICK) begin
         case (phase_ff)
            ST_IGN_WAIT: begin
               timer_in = timer_inc;
               // a wrapped count also ends the wait
               if (timer_inc >= cfg.ignition_delay_ms || timer_inc == '0) begin
                  phase_in = ST_CRANK;
                  timer_in = '0;
               end
            end
            ST_CRANK: begin
               if (req.battery_mv >= cfg.starter_stop_mv) begin
                  phase_in         = ST_RUN;
                  timer_in         = '0;
                  rsp.notice_valid = 1'b1;
                  rsp.notice_code  = ress_pkg::NT_STARTED;
               end else if (timer_ff >= cfg.crank_timeout_ms) begin
                  phase_in         = ST_STOPPED;
                  timer_in         = '0;
                  ign_in           = 1'b0;
                  rsp.notice_valid = 1'b1;
                  rsp.notice_code  = ress_pkg::NT_FAILED;
               end else begin
                  timer_in = timer_inc;
               end
            end
            ST_RUN: begin
               if (remote_ff) begin
                  if (minutes_ff != '0) begin
                     millis_in = millis_ff + 10'd1;
                     if (32'(millis_in) >= ress_pkg::TICKS_PER_SECOND) begin
                        seconds_in = seconds_ff + 6'd1;
                        millis_in  = '0;
                     end
                     if (32'(seconds_in) >= ress_pkg::SECONDS_PER_MINUTE) begin
                        minutes_in = minutes_ff - 8'd1;
                        seconds_in = '0;
                     end
                     // key inserted: hand the engine over to the driver
                     if (req.accessory_mv > cfg.key_present_mv) begin
                        ign_in     = 1'b0;
                        remote_in  = 1'b0;
                        millis_in  = '0;
                        seconds_in = '0;
                     end
                  end else begin
                     ign_in           = 1'b0;
                     phase_in         = ST_STOPPED;
                     remote_in        = 1'b0;
                     rsp.notice_valid = 1'b1;
                     rsp.notice_code  = ress_pkg::NT_STOPPED;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (phase_ff != ST_IGN_WAIT && phase_ff != ST_CRANK) begin
         case (req.command_code)
            ress_pkg::CMD_BATTERY: begin
               rsp.reply_valid = 1'b1;
               rsp.reply_data  = ress_pkg::battery_div100(req.battery_mv);
            end
            ress_pkg::CMD_STOP: begin
               rsp.reply_valid  = 1'b1;
               rsp.reply_data   = ress_pkg::RD_OK;
               ign_in           = 1'b0;
               phase_in         = ST_STOPPED;
               remote_in        = 1'b0;
               rsp.notice_valid = 1'b1;
               rsp.notice_code  = ress_pkg::NT_STOPPED;
            end
            ress_pkg::CMD_IND_A, ress_pkg::CMD_IND_B: begin
               rsp.reply_valid = 1'b1;
               rsp.reply_data  = ress_pkg::RD_OK;
               if (req.command_arg != ress_pkg::ARG_UNCHANGED) begin
                  indicator_in = req.command_arg;
               end
            end
            ress_pkg::CMD_START_10, ress_pkg::CMD_START_15, ress_pkg::CMD_START_20,
            ress_pkg::CMD_START_25, ress_pkg::CMD_START_30: begin
               rsp.reply_valid = 1'b1;
               if (req.battery_mv > cfg.engine_running_mv) begin
                  phase_in         = ST_RUN;
                  rsp.reply_data   = ress_pkg::RD_RUNNING;
                  rsp.notice_valid = 1'b1;
                  rsp.notice_code  = ress_pkg::NT_RUNNING;
               end else begin
                  if (req.command_arg != ress_pkg::ARG_UNCHANGED) begin
                     minutes_in = req.command_arg;
                  end
                  rsp.reply_data = ress_pkg::RD_STARTING;
                  remote_in      = 1'b1;
                  ign_in         = 1'b1;
                  phase_in       = ST_IGN_WAIT;
                  timer_in       = '0;
               end
            end
            default: begin
            end
         endcase
         if (rsp.reply_valid) begin
            rsp.reply_result = ress_pkg::REPLY_BASE + req.command_code;
         end
      end

      rsp.ignition_relay  = ign_in;
      rsp.starter_relay   = (phase_in == ST_CRANK);
      rsp.indicator_level = indicator_in;
      rsp.engine_phase    = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_STOPPED;
         timer_ff     <= '0;
         minutes_ff   <= '0;
         millis_ff    <= '0;
         seconds_ff   <= '0;
         remote_ff    <= 1'b0;
         ign_ff       <= 1'b0;
         indicator_ff <= ress_pkg::RST_INDICATOR;
      end else if (accept) begin
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         minutes_ff   <= minutes_in;
         millis_ff    <= millis_in;
         seconds_ff   <= seconds_in;
         remote_ff    <= remote_in;
         ign_ff       <= ign_in;
         indicator_ff <= indicator_in;
      end
   end

endmodule

@@ hw/rtl/ress_checker.sv @@
// Port-level checks for the remote engine start sequencer, bound to the top.
// Depends on ress_pkg and remote_engine_start_sequencer_top_macros.svh.
`timescale 1ns / 1ps
`include "remote_engine_start_sequencer_top_macros.svh"

module ress_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ress_pkg::rsp_type rsp_data
);

   // a held result keeps its payload
   `RESS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // every accepted transaction shows its result on the next cycle
   `RESS_ASSERT_NEXT(a_one_result, clock, reset, req_valid && !req_stall, rsp_valid)

   // ignition stays on through the whole start sequence
   `RESS_ASSERT_NOW(a_ign_during_start, clock, reset, rsp_valid && (rsp_data.engine_phase == ress_pkg::PH_IGN_WAIT || rsp_data.engine_phase == ress_pkg::PH_CRANK), rsp_data.ignition_relay)

   // no reply means empty reply bytes
   `RESS_ASSERT_NOW(a_reply_clean, clock, reset, rsp_valid && !rsp_data.reply_valid, rsp_data.reply_result == '0 && rsp_data.reply_data == '0)

endmodule

bind remote_engine_start_sequencer_top ress_checker u_ress_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ tb/sv/remote_engine_start_sequencer_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for remote_engine_start_sequencer_top: directed and random
// transactions against an in-bench sequencer predictor, with random idling and stalls.
// Depends on ress_pkg and the remote_engine_start_sequencer_top RTL.

module remote_engine_start_sequencer_top_tb;
   import ress_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = 3;
   localparam int unsigned HOLD_OFF_CYCLES = 64;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MV_W-1:0]      csr_wdata = '0;

   remote_engine_start_sequencer_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   cfg_type          seq_cfg;
   logic [1:0]       seq_phase;
   logic [15:0]      seq_timer;
   logic [7:0]       seq_minutes;
   int unsigned      seq_millis;
   int unsigned      seq_seconds;
   logic             seq_remote_run;
   logic             seq_ignition;
   logic [7:0]       seq_indicator;

   rsp_type          expected_status_q[$];
   int unsigned      items_sent = 0;
   int unsigned      status_checked = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      notice_tally[4] = '{0, 0, 0, 0};
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   int unsigned      hold_request = 0;
   int unsigned      quiet_cycles = 0;

   function automatic rsp_type predict_status(input req_type item);
      rsp_type     r;
      int unsigned decivolts;
      r = '0;
      if (item.mode == MODE_TICK) begin
         case (seq_phase)
            PH_IGN_WAIT: begin
               seq_timer = seq_timer + 16'd1;
               // a wrapped timer also ends the wait
               if (seq_timer >= seq_cfg.ignition_delay_ms || seq_timer == 16'd0) begin
                  seq_phase = PH_CRANK;
                  seq_timer = '0;
               end
            end
            PH_CRANK: begin
               if (item.battery_mv >= seq_cfg.starter_stop_mv) begin
                  seq_phase = PH_RUN;
                  seq_timer = '0;
                  r.notice_valid = 1'b1;
                  r.notice_code = NT_STARTED;
               end else if (seq_timer >= seq_cfg.crank_timeout_ms) begin
                  seq_phase = PH_STOPPED;
                  seq_timer = '0;
                  seq_ignition = 1'b0;
                  r.notice_valid = 1'b1;
                  r.notice_code = NT_FAILED;
               end else begin
                  seq_timer = seq_timer + 16'd1;
               end
            end
            PH_RUN: begin
               if (seq_remote_run) begin
                  if (seq_minutes != 8'd0) begin
                     seq_millis++;
                     if (seq_millis >= TICKS_PER_SECOND) begin
                        seq_seconds++;
                        seq_millis = 0;
                     end
                     if (seq_seconds >= SECONDS_PER_MINUTE) begin
                        seq_minutes--;
                        seq_seconds = 0;
                     end
                     if (item.accessory_mv > seq_cfg.key_present_mv) begin
                        seq_ignition = 1'b0;
                        seq_remote_run = 1'b0;
                        seq_millis = 0;
                        seq_seconds = 0;
                     end
                  end else begin
                     seq_ignition = 1'b0;
                     seq_phase = PH_STOPPED;
                     seq_remote_run = 1'b0;
                     r.notice_valid = 1'b1;
                     r.notice_code = NT_STOPPED;
                  end
               end
            end
            default: ;
         endcase
      end else if (seq_phase != PH_IGN_WAIT && seq_phase != PH_CRANK) begin
         case (item.command_code)
            CMD_BATTERY: begin
               decivolts = item.battery_mv / 100;
               r.reply_valid = 1'b1;
               r.reply_data = (decivolts > 255) ? 8'd255 : 8'(decivolts);
            end
            CMD_STOP: begin
               r.reply_valid = 1'b1;
               r.reply_data = RD_OK;
               seq_ignition = 1'b0;
               seq_phase = PH_STOPPED;
               seq_remote_run = 1'b0;
               r.notice_valid = 1'b1;
               r.notice_code = NT_STOPPED;
            end
            CMD_IND_A, CMD_IND_B: begin
               r.reply_valid = 1'b1;
               r.reply_data = RD_OK;
               if (item.command_arg != ARG_UNCHANGED) seq_indicator = item.command_arg;
            end
            CMD_START_10, CMD_START_15, CMD_START_20, CMD_START_25, CMD_START_30: begin
               r.reply_valid = 1'b1;
               if (item.battery_mv > seq_cfg.engine_running_mv) begin
                  seq_phase = PH_RUN;
                  r.reply_data = RD_RUNNING;
                  r.notice_valid = 1'b1;
                  r.notice_code = NT_RUNNING;
               end else begin
                  if (item.command_arg != ARG_UNCHANGED) seq_minutes = item.command_arg;
                  r.reply_data = RD_STARTING;
                  seq_remote_run = 1'b1;
                  seq_ignition = 1'b1;
                  seq_phase = PH_IGN_WAIT;
                  seq_timer = '0;
               end
            end
            default: ;
         endcase
         if (r.reply_valid) r.reply_result = REPLY_BASE + item.command_code;
      end
      if (r.notice_valid) notice_tally[r.notice_code]++;
      r.ignition_relay = seq_ignition;
      r.starter_relay = (seq_phase == PH_CRANK);
      r.indicator_level = seq_indicator;
      r.engine_phase = seq_phase;
      return r;
   endfunction

   // ---------------- result checking ----------------
   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_status_q.size() == 0) begin
            $error("result transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_status_q.pop_front();
            status_checked++;
            check_field("ignition_relay", 16'(want.ignition_relay),
                        16'(rsp_data.ignition_relay));
            check_field("starter_relay", 16'(want.starter_relay),
                        16'(rsp_data.starter_relay));
            check_field("indicator_level", 16'(want.indicator_level),
                        16'(rsp_data.indicator_level));
            check_field("engine_phase", 16'(want.engine_phase), 16'(rsp_data.engine_phase));
            check_field("reply_valid", 16'(want.reply_valid), 16'(rsp_data.reply_valid));
            check_field("reply_result", 16'(want.reply_result), 16'(rsp_data.reply_result));
            check_field("reply_data", 16'(want.reply_data), 16'(rsp_data.reply_data));
            check_field("notice_valid", 16'(want.notice_valid), 16'(rsp_data.notice_valid));
            check_field("notice_code", 16'(want.notice_code), 16'(rsp_data.notice_code));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      int unsigned hold_left;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request != 0) begin
         hold_left = hold_request - 1;
         hold_request = 0;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transaction for %0d cycles, %0d results outstanding",
                quiet_cycles, expected_status_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- stimulus helpers ----------------
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_status_q.push_back(predict_status(item));
      items_sent++;
   endtask

   // called right at an acceptance edge or while idle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input cfg_type c);
      drain();
      csr_write_en <= 1'b1;
      csr_index <= REG_STARTER_STOP;
      csr_wdata <= c.starter_stop_mv;
      @(posedge clock);
      csr_index <= REG_ENGINE_RUNNING;
      csr_wdata <= c.engine_running_mv;
      @(posedge clock);
      csr_index <= REG_KEY_PRESENT;
      csr_wdata <= c.key_present_mv;
      @(posedge clock);
      csr_index <= REG_IGN_DELAY;
      csr_wdata <= c.ignition_delay_ms;
      @(posedge clock);
      csr_index <= REG_CRANK_TIMEOUT;
      csr_wdata <= c.crank_timeout_ms;
      @(posedge clock);
      csr_write_en <= 1'b0;
      seq_cfg = c;
   endtask

   function automatic req_type make_tick(input logic [15:0] bat, input logic [15:0] acc);
      req_type t;
      t.mode = MODE_TICK;
      t.command_code = 8'($urandom);
      t.command_arg = 8'($urandom);
      t.battery_mv = bat;
      t.accessory_mv = acc;
      return t;
   endfunction

   function automatic req_type make_command(input logic [7:0] code, input logic [7:0] arg,
                                            input logic [15:0] bat, input logic [15:0] acc);
      req_type t;
      t.mode = MODE_COMMAND;
      t.command_code = code;
      t.command_arg = arg;
      t.battery_mv = bat;
      t.accessory_mv = acc;
      return t;
   endfunction

   function automatic logic [15:0] any_mv();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] mv_below(input logic [15:0] thr);
      if (thr == 16'd0) return 16'd0;
      case ($urandom_range(7))
         0, 1: return thr - 16'd1;
         2: return 16'd0;
         default: return 16'($urandom_range(int'(thr) - 1, 0));
      endcase
   endfunction

   function automatic logic [15:0] mv_at_least(input logic [15:0] thr);
      case ($urandom_range(7))
         0, 1: return thr;
         2: return 16'hFFFF;
         default: return 16'($urandom_range(65535, int'(thr)));
      endcase
   endfunction

   function automatic logic [15:0] mv_at_most(input logic [15:0] thr);
      if ($urandom_range(3) == 0) return thr;
      return 16'($urandom_range(int'(thr), 0));
   endfunction

   function automatic logic [15:0] mv_above(input logic [15:0] thr);
      if (thr == 16'hFFFF) return thr;
      if ($urandom_range(3) == 0) return thr + 16'd1;
      return 16'($urandom_range(65535, int'(thr) + 1));
   endfunction

   function automatic logic [7:0] pick_start_code();
      case ($urandom_range(4))
         0: return CMD_START_10;
         1: return CMD_START_15;
         2: return CMD_START_20;
         3: return CMD_START_25;
         default: return CMD_START_30;
      endcase
   endfunction

   function automatic req_type noise_item();
      logic [7:0] code;
      logic [7:0] arg;
      case ($urandom_range(9))
         0: code = CMD_BATTERY;
         1: code = CMD_STOP;
         2: code = CMD_IND_A;
         3: code = CMD_IND_B;
         4: code = pick_start_code();
         default: code = 8'($urandom);
      endcase
      arg = ($urandom_range(4) == 0) ? ARG_UNCHANGED : 8'($urandom);
      if ($urandom_range(1) == 0) return make_tick(any_mv(), any_mv());
      return make_command(code, arg, any_mv(), any_mv());
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.starter_stop_mv = ($urandom_range(1) == 0) ? 16'($urandom_range(14000, 11000))
                                                   : 16'($urandom);
      c.engine_running_mv = ($urandom_range(1) == 0) ? 16'($urandom_range(15000, 12000))
                                                     : 16'($urandom);
      c.key_present_mv = ($urandom_range(1) == 0) ? 16'($urandom_range(12000, 6000))
                                                  : 16'($urandom);
      c.ignition_delay_ms = 16'($urandom_range(12, 0));
      c.crank_timeout_ms = 16'($urandom_range(15, 0));
      return c;
   endfunction

   // one remote start from request through cranking and a short run, then a key-in, a stop, both or neither
   task automatic run_start_sequence();
      logic [7:0]  arg;
      logic [15:0] bat;
      int unsigned crank_ticks;
      int unsigned run_ticks;
      int unsigned n;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) arg = ARG_UNCHANGED;
      else if (pick < 35) arg = 8'd0;
      else if (pick < 50) arg = 8'($urandom_range(3, 1));
      else arg = 8'($urandom_range(254, 0));
      bat = ($urandom_range(99) < 15) ? mv_above(seq_cfg.engine_running_mv)
                                      : mv_at_most(seq_cfg.engine_running_mv);
      send_request(make_command(pick_start_code(), arg, bat, any_mv()));

      while (seq_phase == PH_IGN_WAIT) begin
         if ($urandom_range(99) < 10) send_request(noise_item());
         else send_request(make_tick(any_mv(), any_mv()));
      end

      crank_ticks = $urandom_range(int'(seq_cfg.crank_timeout_ms) + 2, 0);
      if (crank_ticks > 40) crank_ticks = 40;
      n = 0;
      while (seq_phase == PH_CRANK) begin
         if ($urandom_range(99) < 8) begin
            send_request(noise_item());
         end else if (n < crank_ticks) begin
            send_request(make_tick(mv_below(seq_cfg.starter_stop_mv), any_mv()));
            n++;
         end else begin
            send_request(make_tick(mv_at_least(seq_cfg.starter_stop_mv), any_mv()));
         end
      end

      if (seq_phase == PH_RUN) begin
         run_ticks = $urandom_range(30, 0);
         for (int i = 0; i < run_ticks && seq_phase == PH_RUN; i++) begin
            if ($urandom_range(99) < 10)
               send_request(make_command(($urandom_range(1) == 0) ? CMD_BATTERY : CMD_IND_A,
                                         8'($urandom), any_mv(), any_mv()));
            else
               send_request(make_tick(any_mv(), mv_at_most(seq_cfg.key_present_mv)));
         end
         case ($urandom_range(3))
            0: begin
               send_request(make_tick(any_mv(), mv_above(seq_cfg.key_present_mv)));
               send_request(make_tick(any_mv(), any_mv()));
               send_request(make_command(CMD_STOP, 8'($urandom), any_mv(), any_mv()));
            end
            1: send_request(make_command(CMD_STOP, 8'($urandom), any_mv(), any_mv()));
            2: send_request(make_tick(any_mv(), mv_above(seq_cfg.key_present_mv)));
            default: ;   // leave it running; the next start comes from running
         endcase
      end
   endtask

   task automatic run_traffic(input int unsigned count);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < count) begin
         if ($urandom_range(99) < 70) run_start_sequence();
         else repeat ($urandom_range(6, 1)) send_request(noise_item());
      end
   endtask

   // ---------------- tests ----------------
   task automatic test_directed_commands();
      cfg_type c;
      send_request(make_command(CMD_BATTERY, 8'd0, 16'd0, 16'd0));
      send_request(make_command(CMD_BATTERY, 8'd0, 16'd25499, 16'd0));
      send_request(make_command(CMD_BATTERY, 8'd0, 16'd25600, 16'd0));
      send_request(make_command(CMD_BATTERY, 8'd0, 16'hFFFF, 16'hFFFF));
      send_request(make_command(CMD_IND_A, 8'd0, 16'd0, 16'd0));
      send_request(make_command(CMD_IND_B, 8'd254, 16'd0, 16'd0));
      send_request(make_command(CMD_IND_A, ARG_UNCHANGED, 16'd0, 16'd0));
      send_request(make_command(8'd0, 8'd0, 16'd0, 16'd0));
      send_request(make_command(8'd255, 8'd255, 16'hFFFF, 16'hFFFF));
      send_request(make_command(CMD_STOP, 8'd0, 16'd0, 16'd0));
      // already running at one mV over the reset threshold
      send_request(make_command(CMD_START_10, 8'd5, 16'd13001, 16'd0));
      send_request(make_tick(16'd0, 16'hFFFF));
      send_request(make_command(CMD_STOP, 8'd0, 16'd0, 16'd0));

      c = seq_cfg;
      c.ignition_delay_ms = 16'd0;
      c.crank_timeout_ms = 16'd0;
      write_registers(c);
      // failed start: zero timeout with a low battery
      send_request(make_command(CMD_START_15, 8'd0, 16'd13000, 16'd0));
      send_request(make_command(CMD_BATTERY, 8'd0, 16'd13000, 16'd0));
      send_request(make_tick(16'd0, 16'd0));
      send_request(make_tick(16'd12499, 16'd0));
      // good start, then key cancels the remote run
      send_request(make_command(CMD_START_20, 8'd2, 16'd0, 16'd0));
      send_request(make_tick(16'd0, 16'd0));
      send_request(make_tick(16'd12500, 16'd0));
      send_request(make_tick(16'd0, 16'd9001));
      send_request(make_tick(16'd0, 16'd0));
      send_request(make_command(CMD_STOP, 8'd0, 16'd0, 16'd0));
      // zero minutes: the first running tick stops the engine
      send_request(make_command(CMD_START_30, 8'd0, 16'd12000, 16'd9000));
      send_request(make_tick(16'd0, 16'd0));
      send_request(make_tick(16'hFFFF, 16'd9000));
      send_request(make_tick(16'd0, 16'd9000));
   endtask

   task automatic test_low_thresholds();
      write_registers('0);
      run_traffic(70);
   endtask

   task automatic test_high_thresholds();
      cfg_type c;
      c.starter_stop_mv = 16'hFFFF;
      c.engine_running_mv = 16'hFFFF;
      c.key_present_mv = 16'hFFFF;
      c.ignition_delay_ms = 16'd12;
      c.crank_timeout_ms = 16'd15;
      write_registers(c);
      run_traffic(70);
   endtask

   task automatic test_random_settings(input int unsigned settings, input int unsigned count);
      repeat (settings) begin
         write_registers(random_settings());
         run_traffic(count);
      end
   endtask

   task automatic test_backpressure();
      hold_request = HOLD_OFF_CYCLES;
      run_traffic(60);
   endtask

   task automatic test_pause_until_drained();
      run_traffic(30);
      req_valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      run_traffic(30);
   endtask

   // just over one second of remote run; a stop midway leaves the counts in place
   task automatic test_minute_countdown();
      cfg_type c;
      // finish any start left open by earlier traffic
      while (seq_phase == PH_IGN_WAIT || seq_phase == PH_CRANK)
         send_request(make_tick(16'd14000, 16'd0));
      c = random_settings();
      c.starter_stop_mv = 16'd12500;
      c.engine_running_mv = 16'd13000;
      c.key_present_mv = 16'd9000;
      write_registers(c);
      send_request(make_command(CMD_STOP, 8'd0, 16'd0, 16'd0));
      send_request(make_command(CMD_START_25, 8'd1, 16'd12000, 16'd0));
      while (seq_phase != PH_RUN) send_request(make_tick(16'd14000, 16'd0));
      repeat (1005) send_request(make_tick(any_mv(), mv_at_most(16'd9000)));
      send_request(make_command(CMD_STOP, 8'd0, 16'd0, 16'd0));
      send_request(make_command(CMD_START_10, ARG_UNCHANGED, 16'd12000, 16'd0));
      while (seq_phase != PH_RUN) send_request(make_tick(16'd14000, 16'd0));
      repeat (20) begin
         if ($urandom_range(9) == 0)
            send_request(make_command(CMD_BATTERY, 8'($urandom), any_mv(), any_mv()));
         else
            send_request(make_tick(any_mv(), mv_at_most(16'd9000)));
      end
      send_request(make_tick(any_mv(), mv_above(16'd9000)));
      send_request(make_command(CMD_STOP, 8'd0, 16'd0, 16'd0));
   endtask

   // longer ignition delay and crank timeout, ending in a failed start
   task automatic test_long_timers();
      cfg_type c;
      c.starter_stop_mv = 16'd12500;
      c.engine_running_mv = 16'd13000;
      c.key_present_mv = 16'd9000;
      c.ignition_delay_ms = 16'd30;
      c.crank_timeout_ms = 16'd30;
      write_registers(c);
      send_request(make_command(CMD_START_20, 8'd3, 16'd11000, 16'd0));
      while (seq_phase == PH_IGN_WAIT) send_request(make_tick(16'd0, any_mv()));
      while (seq_phase == PH_CRANK) send_request(make_tick(mv_below(16'd12500), any_mv()));
   endtask

   initial begin
      seq_cfg = '{RST_STARTER_STOP, RST_ENGINE_RUNNING, RST_KEY_PRESENT,
                  RST_IGN_DELAY, RST_CRANK_TIMEOUT};
      seq_phase = PH_STOPPED;
      seq_timer = '0;
      seq_minutes = '0;
      seq_millis = 0;
      seq_seconds = 0;
      seq_remote_run = 1'b0;
      seq_ignition = 1'b0;
      seq_indicator = RST_INDICATOR;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 87;
      test_directed_commands();
      test_low_thresholds();
      test_random_settings(2, 80);

      send_idle_pct = 87;
      recv_idle_pct = 20;
      test_high_thresholds();
      test_random_settings(2, 80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_settings(1, 80);
      test_backpressure();
      test_pause_until_drained();
      test_minute_countdown();
      test_long_timers();
      drain();

      $display("Sent %0d transactions, checked %0d results; notices started %0d, failed %0d,",
               items_sent, status_checked, notice_tally[NT_STARTED], notice_tally[NT_FAILED]);
      $display("stopped %0d, already running %0d; %0d mismatches.",
               notice_tally[NT_STOPPED], notice_tally[NT_RUNNING], mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ress_pkg.sv
hw/rtl/ress_step.sv
hw/rtl/remote_engine_start_sequencer_top.sv
hw/rtl/ress_checker.sv
tb/sv/remote_engine_start_sequencer_top_tb.sv
